// File: hw/rtl/hdbr_pkg.sv
// ----------------------------------------------------------------------------
// hdbr_pkg: shared types and constants
// Heat grid renderer word formats and the fixed color ramp.
// ----------------------------------------------------------------------------
package hdbr_pkg;

   localparam int PX_W   = 9;
   localparam int PY_W   = 8;
   localparam int HEAT_W = 8;
   localparam int PTR_W  = 10;

   localparam logic CMD_PAINT  = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [PTR_W-1:0] pointer_x;
      logic [PTR_W-1:0] pointer_y;
   } req_type;

   typedef struct packed {
      logic [PX_W-1:0]   pixel_x;
      logic [PY_W-1:0]   pixel_y;
      logic [HEAT_W-1:0] heat;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic              last_pixel;
      logic              frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // ramp entry 0..63, times four, capped
   function automatic logic [7:0] chan(input int v);
      int x;
      x = v * 4;
      if (x > 255) x = 255;
      return 8'(x);
   endfunction

   function automatic rgb_type ramp(input logic [7:0] t);
      int i, r, g, b;
      rgb_type o;
      i = int'(t);
      r = 0; g = 0; b = 0;
      if (i >= 8 && i <= 17) r = (i - 8) * 63 / 10;
      else if (i >= 18 && i < 32) begin
         r = 63 - (i - 18) * 63 / 14;
         g = (i - 18) * 63 / 14;
      end else if (i >= 32 && i <= 55) begin
         g = 63;
         r = (i - 32) * 63 / 23;
      end else if (i >= 56 && i <= 79) begin
         r = 63; g = 63;
         b = (i - 56) * 63 / 23;
      end else if (i >= 80) begin
         r = 63; g = 63; b = 63;
      end
      o.red   = chan(r);
      o.green = chan(g);
      o.blue  = chan(b);
      return o;
   endfunction

endpackage

// File: hw/rtl/hdbr_if.sv
// ----------------------------------------------------------------------------
// hdbr_req_if / hdbr_rsp_if: valid/ready channels
// One word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface hdbr_req_if;
   import hdbr_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hdbr_rsp_if;
   import hdbr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/heat_diffusion_blob_renderer.sv
// ----------------------------------------------------------------------------
// heat_diffusion_blob_renderer: heat grid with blob painting and diffusion
// Front queue takes request words; back engine paints and updates cells.
// ----------------------------------------------------------------------------
// Paint word: one grid write per blob cell in the engine.
// Update word: eight neighbor reads on the one grid RAM port, one write
// back, then four pixel words, one per cycle while the output is not stalled.
// Reset: a clearing pass writes zero to all GRID_WIDTH*GRID_HEIGHT cells;
// queued words wait until it is done.
module heat_diffusion_blob_renderer #(
   parameter int GRID_WIDTH  = 161,
   parameter int GRID_HEIGHT = 101
) (
   input  logic       clock,
   input  logic       reset,
   hdbr_req_if.sink   req,
   hdbr_rsp_if.source rsp
);
   import hdbr_pkg::*;

   logic    q_full, q_empty, q_pop;
   req_type q_data;

   // front: accept whenever the queue has room
   assign req.ready = !q_full;

   hdbr_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(req.valid && !q_full), .push_data(req.data), .full(q_full),
      .pop(q_pop), .pop_data(q_data), .empty(q_empty)
   );

   // back: sequencer over the grid memory
   hdbr_engine #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(!q_empty), .cmd_data(q_data), .cmd_pop(q_pop),
      .rsp(rsp)
   );
endmodule

// File: hw/rtl/hdbr_ram.sv
// ----------------------------------------------------------------------------
// hdbr_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hdbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
endmodule

// File: hw/rtl/hdbr_queue.sv
// ----------------------------------------------------------------------------
// hdbr_queue: small FIFO between front and back
// Holds request words so the front keeps accepting while the back is busy.
// ----------------------------------------------------------------------------
module hdbr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hdbr_pkg::req_type   push_data,
   output logic                full,
   input  logic                pop,
   output hdbr_pkg::req_type   pop_data,
   output logic                empty
);
   import hdbr_pkg::*;
   localparam int AW = $clog2(DEPTH);

   req_type         buf_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = buf_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) buf_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue underflow");
endmodule

// File: hw/rtl/hdbr_engine.sv
// ----------------------------------------------------------------------------
// hdbr_engine: back end, grid clear, paint, diffusion step, pixel emission
// Sequencer over a single-port grid RAM with a registered output stage.
// ----------------------------------------------------------------------------
module hdbr_engine #(
   parameter int GRID_WIDTH  = 161,
   parameter int GRID_HEIGHT = 101
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  hdbr_pkg::req_type   cmd_data,
   output logic                cmd_pop,
   hdbr_rsp_if.source          rsp
);
   import hdbr_pkg::*;

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_WIDTH);
   localparam int RW    = $clog2(GRID_HEIGHT);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PAINT, ST_READ, ST_WRITE, ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     addr_ff;
   logic [CW-1:0]     col_ff, pc_ff;
   logic [RW-1:0]     row_ff, pr_ff;
   logic [3:0]        k_ff;      // neighbor / blob index
   logic [1:0]        bcol_ff;   // blob column 0..2
   logic [2:0]        brow_ff;   // blob row 0..4
   logic [11:0]       sum_ff;
   logic              rd_pend_ff;
   logic [HEAT_W-1:0] heat_ff;
   logic              done_ff;
   logic [1:0]        pix_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              we;
   logic [AW-1:0]     ram_addr;
   logic [HEAT_W-1:0] wdata, rdata;
   rgb_type           rgb;
   rgb_type           ramp_rom [256];

   hdbr_ram #(.WIDTH(HEAT_W), .DEPTH(CELLS)) u_grid (
      .clock(clock), .we(we), .addr(ram_addr), .wdata(wdata), .rdata_ff(rdata)
   );

   function automatic logic [AW-1:0] idx(input logic [CW-1:0] c,
                                         input logic [RW-1:0] r);
      return AW'(r) * AW'(GRID_WIDTH) + AW'(c);
   endfunction

   // color ramp folded to a constant table
   for (genvar g = 0; g < 256; g++) begin : g_ramp
      assign ramp_rom[g] = ramp(8'(g));
   end

   // neighbor k (0..7) offsets
   logic [CW-1:0] nc;
   logic [RW-1:0] nr;
   always_comb begin
      nc = col_ff;
      nr = row_ff;
      case (k_ff[2:0])
         3'd0: begin nc = col_ff + 1'b1; end
         3'd1: begin nc = col_ff - 1'b1; end
         3'd2: begin nc = col_ff + 1'b1; nr = row_ff - 1'b1; end
         3'd3: begin nc = col_ff - 1'b1; nr = row_ff - 1'b1; end
         3'd4: begin nr = row_ff - 1'b1; end
         3'd5: begin nc = col_ff + 1'b1; nr = row_ff + 1'b1; end
         3'd6: begin nr = row_ff + 1'b1; end
         default: begin nc = col_ff - 1'b1; nr = row_ff + 1'b1; end
      endcase
   end

   // blob cell: 3 wide, 5 high, walked column first
   logic [CW-1:0] bc;
   logic [RW-1:0] br;
   always_comb begin
      bc = pc_ff - 1'b1 + CW'(bcol_ff);
      br = pr_ff - RW'(2) + RW'(brow_ff);
   end

   // paint center from pointer
   logic [PTR_W-2:0] hx, hy;
   logic [CW-1:0]    cx;
   logic [RW-1:0]    cy;
   always_comb begin
      hx = cmd_data.pointer_x[PTR_W-1:1];
      hy = cmd_data.pointer_y[PTR_W-1:1];
      if (32'(hx) < 3) cx = CW'(3);
      else if (32'(hx) > GRID_WIDTH - 4) cx = CW'(GRID_WIDTH - 4);
      else cx = CW'(hx);
      if (32'(hy) < 3) cy = RW'(3);
      else if (32'(hy) > GRID_HEIGHT - 4) cy = RW'(GRID_HEIGHT - 4);
      else cy = RW'(hy);
   end

   always_comb begin
      we       = 1'b0;
      wdata    = 8'hFF;
      ram_addr = idx(nc, nr);
      unique case (state_ff)
         ST_CLEAR: begin we = 1'b1; wdata = '0; ram_addr = addr_ff; end
         ST_PAINT: begin we = 1'b1; ram_addr = idx(bc, br); end
         ST_WRITE: begin we = 1'b1; wdata = heat_ff; ram_addr = idx(col_ff, row_ff); end
         default: ;
      endcase
   end

   assign rgb     = ramp_rom[heat_ff];
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         col_ff       <= CW'(1);
         row_ff       <= RW'(1);
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == AW'(CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               k_ff    <= '0;
               bcol_ff <= '0;
               brow_ff <= '0;
               if (cmd_valid) begin
                  if (cmd_data.cmd == CMD_PAINT) begin
                     pc_ff    <= cx;
                     pr_ff    <= cy;
                     state_ff <= ST_PAINT;
                  end else begin
                     sum_ff     <= '0;
                     rd_pend_ff <= 1'b0;
                     state_ff   <= ST_READ;
                  end
               end
            end
            ST_PAINT: begin
               k_ff <= k_ff + 1'b1;
               if (bcol_ff == 2'd2) begin
                  bcol_ff <= '0;
                  brow_ff <= brow_ff + 1'b1;
               end else bcol_ff <= bcol_ff + 1'b1;
               if (k_ff == 4'd14) state_ff <= ST_IDLE;
            end
            ST_READ: begin
               // address k issued; data of previous read arrives now
               if (rd_pend_ff) sum_ff <= sum_ff + 12'(rdata);
               rd_pend_ff <= (k_ff < 4'd8);
               if (k_ff < 4'd8) k_ff <= k_ff + 1'b1;
               if (k_ff == 4'd8 && rd_pend_ff) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               done_ff <= 1'b0;
               if (col_ff == CW'(GRID_WIDTH - 2)) begin
                  col_ff <= CW'(1);
                  if (row_ff == RW'(GRID_HEIGHT - 2)) begin
                     row_ff  <= RW'(1);
                     done_ff <= 1'b1;
                  end else row_ff <= row_ff + 1'b1;
               end else col_ff <= col_ff + 1'b1;
               pc_ff    <= col_ff;
               pr_ff    <= row_ff;
               pix_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff.pixel_x     <= PX_W'({pc_ff, 1'b0} + pix_ff[0]);
                  rsp_ff.pixel_y     <= PY_W'({pr_ff, 1'b0} + pix_ff[1]);
                  rsp_ff.heat        <= heat_ff;
                  rsp_ff.red         <= rgb.red;
                  rsp_ff.green       <= rgb.green;
                  rsp_ff.blue        <= rgb.blue;
                  rsp_ff.last_pixel  <= (pix_ff == 2'd3);
                  rsp_ff.frame_done  <= done_ff;
                  pix_ff <= pix_ff + 1'b1;
                  if (pix_ff == 2'd3) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_READ && k_ff == 4'd8 && rd_pend_ff)
            heat_ff <= 8'((sum_ff + 12'(rdata)) >> 3);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (col_ff >= CW'(1) && col_ff <= CW'(GRID_WIDTH - 2)))
      else $error("scan column out of interior");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (row_ff >= RW'(1) && row_ff <= RW'(GRID_HEIGHT - 2)))
      else $error("scan row out of interior");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("held word changed");
endmodule

// File: sim/heat_diffusion_blob_renderer_test.sv
// ----------------------------------------------------------------------------
// heat_diffusion_blob_renderer_test: self-checking bench for the heat renderer
// Sends paint and update words with random idling, predicts every pixel word
// from a local copy of the heat grid, and compares the words in order.
// ----------------------------------------------------------------------------
module heat_diffusion_blob_renderer_test;
   import hdbr_pkg::*;

   localparam int GW = 161;
   localparam int GH = 101;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdbr_req_if req ();
   hdbr_rsp_if rsp ();

   heat_diffusion_blob_renderer #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: heat grid, scan position
   logic [7:0] grid [GW*GH];
   int         scan_col;
   int         scan_row;
   rsp_type    pixel_queue [$];

   int  errors      = 0;
   int  cycles      = 0;
   int  n_paint     = 0;
   int  n_update    = 0;
   int  n_rows      = 0;
   int  n_pixels    = 0;
   bit  stall_ready = 1'b1;   // sink side idling on/off
   bit  stall_valid = 1'b1;   // source side idling on/off

   // 6-bit ramp entry times four, capped
   function automatic logic [7:0] scale4(input int v);
      return (v * 4 > 255) ? 8'd255 : 8'(v * 4);
   endfunction

   // black -> red -> green -> yellow -> white; red peaks at index 18
   function automatic rgb_type heat_color(input logic [7:0] t);
      int i, r, g, b;
      rgb_type o;
      i = int'(t);
      r = 0; g = 0; b = 0;
      if (i >= 80) begin
         r = 63; g = 63; b = 63;
      end else if (i >= 56) begin
         r = 63; g = 63; b = (i - 56) * 63 / 23;
      end else if (i >= 32) begin
         g = 63; r = (i - 32) * 63 / 23;
      end else if (i >= 18) begin
         r = 63 - (i - 18) * 63 / 14; g = (i - 18) * 63 / 14;
      end else if (i >= 8) begin
         r = (i - 8) * 63 / 10;
      end
      o.red = scale4(r); o.green = scale4(g); o.blue = scale4(b);
      return o;
   endfunction

   function automatic int at(input int c, input int r);
      return r * GW + c;
   endfunction

   // blob 3 wide, 5 high, centered on the clamped half-pointer
   function automatic void paint_blob(input logic [9:0] px, input logic [9:0] py);
      int gc, gr;
      gc = int'(px) >> 1;
      gr = int'(py) >> 1;
      if (gc < 3) gc = 3;
      if (gr < 3) gr = 3;
      if (gc > GW - 4) gc = GW - 4;
      if (gr > GH - 4) gr = GH - 4;
      for (int r = gr - 2; r <= gr + 2; r++)
         for (int c = gc - 1; c <= gc + 1; c++)
            grid[at(c, r)] = 8'hFF;
   endfunction

   // in-place update: left/upper neighbors are already new
   function automatic void diffuse_cell();
      int c, r, sum;
      logic [7:0] t;
      bit done;
      rgb_type col;
      rsp_type w;
      c = scan_col;
      r = scan_row;
      sum = grid[at(c+1, r)] + grid[at(c-1, r)] + grid[at(c+1, r-1)]
          + grid[at(c-1, r-1)] + grid[at(c, r-1)] + grid[at(c+1, r+1)]
          + grid[at(c, r+1)] + grid[at(c-1, r+1)];
      t = 8'(sum >> 3);
      grid[at(c, r)] = t;
      done = 1'b0;
      scan_col = c + 1;
      if (scan_col > GW - 2) begin
         scan_col = 1;
         scan_row = r + 1;
         if (scan_row > GH - 2) begin
            scan_row = 1;
            done = 1'b1;
         end
      end
      col = heat_color(t);
      for (int k = 0; k < 4; k++) begin
         w.pixel_x    = PX_W'(2 * c + (k & 1));
         w.pixel_y    = PY_W'(2 * r + (k >> 1));
         w.heat       = t;
         w.red        = col.red;
         w.green      = col.green;
         w.blue       = col.blue;
         w.last_pixel = (k == 3);
         w.frame_done = done;
         pixel_queue.push_back(w);
      end
   endfunction

   // send one word; idles a random burst first when enabled
   task automatic send_word(input logic cmd, input logic [9:0] px, input logic [9:0] py);
      req_type d;
      if (stall_valid && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      d.cmd = cmd; d.pointer_x = px; d.pointer_y = py;
      req.valid <= 1'b1;
      req.data  <= d;
      do @(posedge clock); while (!req.ready);
      if (cmd == CMD_PAINT) begin
         paint_blob(px, py);
         n_paint++;
      end else begin
         diffuse_cell();
         n_update++;
      end
   endtask

   task automatic drop_valid();
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pixel_queue.size() != 0) @(posedge clock);
   endtask

   // --- tests ---

   // pointer extremes and blobs touching each clamp edge
   task automatic test_paint_corners();
      send_word(CMD_PAINT, 10'd0, 10'd0);
      send_word(CMD_PAINT, 10'd1023, 10'd1023);
      send_word(CMD_PAINT, 10'd0, 10'd1023);
      send_word(CMD_PAINT, 10'd1023, 10'd0);
      send_word(CMD_PAINT, 10'd7, 10'd7);
      send_word(CMD_PAINT, 10'd314, 10'd194);
      send_word(CMD_PAINT, 10'h2AA, 10'h155);
      send_word(CMD_PAINT, 10'h155, 10'h2AA);
      send_word(CMD_PAINT, 10'd40, 10'd10);
   endtask

   // updates across the hot top-left corner; ramp goes through many shades
   task automatic test_update_row();
      for (int i = 0; i < 14; i++) send_word(CMD_UPDATE, 10'($urandom), 10'($urandom));
   endtask

   // paint mid-frame leaves the scan alone
   task automatic test_paint_mid_frame();
      send_word(CMD_PAINT, 10'd20, 10'd4);
      send_word(CMD_UPDATE, 10'd0, 10'd0);
      send_word(CMD_PAINT, 10'd30, 10'd8);
      send_word(CMD_UPDATE, 10'd0, 10'd0);
   endtask

   // random mix, mostly updates, with blobs near the scan line
   task automatic test_random(input int count);
      logic [9:0] px, py;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1)) begin
               px = 10'(2 * scan_col + $urandom_range(0, 12));
               py = 10'(2 * scan_row + $urandom_range(0, 10));
            end else begin
               px = 10'($urandom);
               py = 10'($urandom);
            end
            send_word(CMD_PAINT, px, py);
         end else begin
            send_word(CMD_UPDATE, 10'($urandom), 10'($urandom));
         end
         if (i == count / 2) wait_drained();   // sender holds off until all pixels land
      end
   endtask

   // back-to-back updates up to the next row wrap, idling off
   task automatic test_row_wrap();
      int start_row;
      stall_valid = 1'b0;
      stall_ready = 1'b0;
      start_row = scan_row;
      while (scan_row == start_row) send_word(CMD_UPDATE, 10'd0, 10'd0);
      n_rows++;
      // a few updates into the new row
      for (int i = 0; i < 6; i++) send_word(CMD_UPDATE, 10'd3, 10'd3);
   endtask

   // --- result side ---

   // ready idles in random bursts when enabled
   int ready_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         rsp.ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if (stall_ready && $urandom_range(0, 7) == 0) begin
         rsp.ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 9);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type e, a;
      if (!reset && rsp.valid && rsp.ready) begin
         a = rsp.data;
         n_pixels++;
         if (pixel_queue.size() == 0) begin
            $error("pixel word with none expected: %p", a);
            errors++;
         end else begin
            e = pixel_queue.pop_front();
            if (a.pixel_x != e.pixel_x) begin
               $error("pixel_x expected %0d actual %0d", e.pixel_x, a.pixel_x); errors++;
            end
            if (a.pixel_y != e.pixel_y) begin
               $error("pixel_y expected %0d actual %0d", e.pixel_y, a.pixel_y); errors++;
            end
            if (a.heat != e.heat) begin
               $error("heat expected %0d actual %0d", e.heat, a.heat); errors++;
            end
            if (a.red != e.red) begin
               $error("red expected %0d actual %0d", e.red, a.red); errors++;
            end
            if (a.green != e.green) begin
               $error("green expected %0d actual %0d", e.green, a.green); errors++;
            end
            if (a.blue != e.blue) begin
               $error("blue expected %0d actual %0d", e.blue, a.blue); errors++;
            end
            if (a.last_pixel != e.last_pixel) begin
               $error("last_pixel expected %0d actual %0d", e.last_pixel, a.last_pixel);
               errors++;
            end
            if (a.frame_done != e.frame_done) begin
               $error("frame_done expected %0d actual %0d", e.frame_done, a.frame_done);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      foreach (grid[i]) grid[i] = 8'h00;
      scan_col = 1;
      scan_row = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_paint_corners();
      test_update_row();
      test_paint_mid_frame();
      test_random(340);
      test_row_wrap();
      wait_drained();
      repeat (40) @(posedge clock);

      $display("covered %0d paints, %0d cell updates, %0d pixel words, %0d row wraps",
               n_paint, n_update, n_pixels, n_rows);
      if (errors == 0 && pixel_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/hdbr_pkg.sv
hw/rtl/hdbr_if.sv
hw/rtl/hdbr_ram.sv
hw/rtl/hdbr_queue.sv
hw/rtl/hdbr_engine.sv
hw/rtl/heat_diffusion_blob_renderer.sv
sim/heat_diffusion_blob_renderer_test.sv
